### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the decoder datapath; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define HUFD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("hufd assertion failed");
// next-cycle implication, disabled while in reset
`define HUFD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("hufd assertion failed");
`else
`define HUFD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define HUFD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### src/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg
// types and constants of the huffman tree walk decoder
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [SYM_W-1:0] END_RESET     = 8'h2A;

  // input mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // register select, paddr bit 2
  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic              is_leaf;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } hufd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_end;
    logic             last;
  } hufd_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write one node entry
    logic dec_start;   // latch a decode byte
    logic halt_final;  // final byte while halted: rearm
    logic rd_cur;      // read the entry at the walk position
    logic step;        // consume one code bit, read the child
    logic emit;        // leaf reached: queue its result
    logic flush;       // end of byte: release the held result
  } hufd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic leaf_hit;
    logic is_end_sym;
    logic bits_left;
    logic can_push;
  } hufd_stat_t;

endpackage

### src/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// decodes packed huffman code bytes by walking a node table loaded beforehand
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  hufd_in_t: load entry or code byte
//  out_      output     out_valid/out_stall  hufd_out_t: symbol, is_end, last
//  cfg (apb) input      psel/penable/pready  root_index (0x0), end_symbol (0x4)
//
//  a load transaction and a byte on a halted decoder complete in the idle state;
//  a decode byte does one dependent read of the single-port node table per code
//  bit, and each leaf reached before its last bit costs a re-read of the root
//  entry
//  rst_n (synchronous) clears the walk to node 0, the halted flag and all valids;
//  the node table holds garbage until written
//  out_stall only holds the walk when a result must move into a full output
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  hufd_pkg::hufd_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output hufd_pkg::hufd_out_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [hufd_pkg::IDX_W-1:0] root_r;
  logic [hufd_pkg::SYM_W-1:0] end_r;
  logic                       cfg_we;

  hufd_pkg::hufd_cmd_t  cmd;
  hufd_pkg::hufd_stat_t stat;

  assign pready = 1'b1;
  // write completes in the access phase
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      end_r  <= hufd_pkg::END_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == hufd_pkg::REG_ROOT) begin
        root_r <= pwdata[hufd_pkg::IDX_W-1:0];
      end else begin
        end_r <= pwdata[hufd_pkg::SYM_W-1:0];
      end
    end
  end

  // read mux, register picked by address bit 2
  always_comb begin
    if (paddr[2] == hufd_pkg::REG_END) begin
      prdata = {{(32-hufd_pkg::SYM_W){1'b0}}, end_r};
    end else begin
      prdata = {{(32-hufd_pkg::IDX_W){1'b0}}, root_r};
    end
  end

  // sequencer: one transaction at a time, walks the byte bit by bit
  hufd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_final (in_data.final_byte),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // node table, walk registers, held result and output register
  hufd_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .root_index (root_r),
    .end_symbol (end_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### src/hufd_ctrl.sv
// ----------------------------------------------------------------------------
// hufd_ctrl
// sequencer of the tree walk: accept, read, walk bit by bit, flush
// ----------------------------------------------------------------------------
module hufd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  input  logic                 in_final,
  output logic                 in_stall,
  input  hufd_pkg::hufd_stat_t stat,
  output hufd_pkg::hufd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } hufd_state_t;

  hufd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == hufd_pkg::MODE_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.halted) begin
            cmd.halt_final = in_final;
          end else begin
            cmd.dec_start = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = ST_WALK;
      end
      ST_WALK: begin
        if (stat.leaf_hit) begin
          if (stat.can_push) begin
            cmd.emit = 1'b1;
            if (stat.is_end_sym || !stat.bits_left) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end else if (stat.bits_left) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.can_push) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### src/hufd_datapath.sv
// ----------------------------------------------------------------------------
// hufd_datapath
// node table, walk position, code bit shifter and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hufd_datapath #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hufd_pkg::hufd_in_t                in_data,
  input  logic [hufd_pkg::IDX_W-1:0]        root_index,
  input  logic [hufd_pkg::SYM_W-1:0]        end_symbol,
  input  hufd_pkg::hufd_cmd_t               cmd,
  output hufd_pkg::hufd_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hufd_pkg::hufd_out_t               out_data
);

  localparam int IDX_W   = hufd_pkg::IDX_W;
  localparam int CNT_W   = hufd_pkg::CNT_W;
  localparam int ADDR_W  = $clog2(NODE_COUNT);
  localparam int ENTRY_W = 2 * IDX_W + 1 + SYMBOL_BITS;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(NODE_COUNT);
  endfunction

  // entry layout: leaf, symbol, right, left
  logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
  logic [ENTRY_W-1:0] rd_q_r;
  logic               oob_r;

  logic [ENTRY_W-1:0]           node;
  logic [IDX_W-1:0]             node_left, node_right, next_idx, rd_idx;
  logic [SYMBOL_BITS-1:0]       node_sym;
  logic                         node_leaf;
  logic [ADDR_W-1:0]            mem_addr;
  logic                         mem_we, mem_re;
  logic [ENTRY_W-1:0]           wr_entry;

  logic [IDX_W-1:0]             walk_r, walk_nxt;
  logic [hufd_pkg::BYTE_W-1:0]  byte_r;
  logic [hufd_pkg::CNT_W-1:0]   cnt_r;
  logic                         first_r, final_r, halted_r, halted_nxt;
  hufd_pkg::hufd_out_t          pend_r, out_data_r, new_res;
  logic                         pend_valid_r, out_valid_r, out_valid_nxt;
  logic                         out_free, push_out, is_end_sym;

  // ---- node table, single port
  assign node       = oob_r ? '0 : rd_q_r;
  assign node_left  = node[IDX_W-1:0];
  assign node_right = node[2*IDX_W-1:IDX_W];
  assign node_sym   = node[2*IDX_W+SYMBOL_BITS-1:2*IDX_W];
  assign node_leaf  = node[ENTRY_W-1];

  assign next_idx = byte_r[hufd_pkg::BYTE_W-1] ? node_right : node_left;
  assign rd_idx   = cmd.step ? next_idx : walk_r;
  assign mem_addr = cmd.load ? ADDR_W'(in_data.node_index) : ADDR_W'(rd_idx);
  assign mem_we   = cmd.load && idx_ok(in_data.node_index);
  assign mem_re   = cmd.rd_cur || cmd.step;
  assign wr_entry = {in_data.is_leaf, SYMBOL_BITS'(in_data.leaf_symbol),
                     in_data.right_child, in_data.left_child};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_addr] <= wr_entry;
    end
    if (mem_re) begin
      rd_q_r <= node_mem[mem_addr];
      oob_r  <= !idx_ok(rd_idx);
    end
  end

  // ---- result path
  assign is_end_sym = (8'(node_sym) == end_symbol);
  assign out_free   = !out_valid_r || !out_stall;
  assign push_out   = (cmd.emit || cmd.flush) && pend_valid_r;

  always_comb begin
    new_res.symbol = is_end_sym ? '0 : 8'(node_sym);
    new_res.is_end = is_end_sym;
    new_res.last   = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (push_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---- walk state
  always_comb begin
    walk_nxt   = walk_r;
    halted_nxt = halted_r;
    if (cmd.step) begin
      walk_nxt = next_idx;
    end
    if (cmd.emit) begin
      walk_nxt = root_index;
      if (is_end_sym) begin
        halted_nxt = 1'b1;
      end
    end
    if (cmd.halt_final || (cmd.flush && final_r)) begin
      walk_nxt   = root_index;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r       <= '0;
      halted_r     <= 1'b0;
      cnt_r        <= '0;
      first_r      <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      walk_r      <= walk_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.dec_start) begin
        cnt_r <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.rd_cur) begin
        first_r <= 1'b1;
      end else if (cmd.step) begin
        first_r <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_start) begin
      byte_r  <= in_data.data_byte;
      final_r <= in_data.final_byte;
    end else if (cmd.step) begin
      byte_r <= {byte_r[hufd_pkg::BYTE_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      pend_r <= new_res;
    end
    // held result moves out; last only on the end-of-byte flush
    if (push_out) begin
      out_data_r <= {pend_r.symbol, pend_r.is_end, cmd.flush};
    end
  end

  always_comb begin
    stat.halted     = halted_r;
    stat.leaf_hit   = !first_r && node_leaf;
    stat.is_end_sym = is_end_sym;
    stat.bits_left  = (cnt_r < hufd_pkg::BITS_PER_BYTE);
    stat.can_push   = !pend_valid_r || out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HUFD_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= hufd_pkg::BITS_PER_BYTE)
  `HUFD_ASSERT_IMP(a_step_has_bit, clk, rst_n, cmd.step, cnt_r < hufd_pkg::BITS_PER_BYTE)
  `HUFD_ASSERT_IMP(a_no_overwrite, clk, rst_n, push_out, out_free)
  `HUFD_ASSERT_NXT(a_end_halts, clk, rst_n, cmd.emit && is_end_sym, halted_r)

endmodule

### sim/tb_huffman_tree_walk_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder
// self-checking bench for the huffman tree walk decoder: loads node tables,
// streams code bytes with random gaps and output stalls, and checks every
// decoded symbol against a walk of a shadow copy of the node table
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder;

  localparam int IDX_W        = hufd_pkg::IDX_W;
  localparam int SYM_W        = hufd_pkg::SYM_W;
  localparam int BYTE_W       = hufd_pkg::BYTE_W;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYC   = 40;    // longer than the worst decode byte
  localparam int RANDOM_ITEMS = 200;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hufd_pkg::hufd_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hufd_pkg::hufd_out_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // shadow of the decoder: node table, walk state and registers
  logic [IDX_W-1:0] node_left  [512];
  logic [IDX_W-1:0] node_right [512];
  logic             node_leaf  [512];
  logic [SYM_W-1:0] node_sym   [512];
  logic [IDX_W-1:0] walk_pos;
  logic             decoder_halted;
  logic [IDX_W-1:0] root_sel;
  logic [SYM_W-1:0] end_sym;

  // nodes that were ever loaded; every loaded node only points at loaded nodes
  bit               node_written [512];
  logic [IDX_W-1:0] written_nodes [$];

  hufd_pkg::hufd_out_t pending_symbols [$];
  hufd_pkg::hufd_out_t front_symbol;

  int          err_count;
  int          items_sent;
  int          cycle_count;
  int          hold_left;     // long receiver hold-off, counted by the stall process
  int          burst_left;
  int unsigned stall_roll;
  bit          no_idle;       // stretches with neither side idling

  huffman_tree_walk_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // expected symbols: apply one accepted transaction to the shadow decoder
  // ---------------------------------------------------------------------------
  task automatic walk_tree(input hufd_pkg::hufd_in_t t);
    hufd_pkg::hufd_out_t found [8];
    int                  n_found;
    int                  b;
    logic [IDX_W-1:0]    nxt;
    n_found = 0;
    if (t.mode == hufd_pkg::MODE_LOAD) begin
      // loads touch only the table, also while halted
      node_left[t.node_index]  = t.left_child;
      node_right[t.node_index] = t.right_child;
      node_leaf[t.node_index]  = t.is_leaf;
      node_sym[t.node_index]   = t.leaf_symbol;
    end else begin
      // msb first; a halted decoder skips the loop entirely
      for (b = BYTE_W - 1; b >= 0 && !decoder_halted; b--) begin
        nxt = t.data_byte[b] ? node_right[walk_pos] : node_left[walk_pos];
        walk_pos = nxt;
        if (node_leaf[walk_pos]) begin
          if (node_sym[walk_pos] == end_sym) begin
            // end leaf: marker, halt, drop the remaining bits
            found[n_found] = '{symbol: '0, is_end: 1'b1, last: 1'b0};
            decoder_halted = 1'b1;
          end else begin
            found[n_found] = '{symbol: node_sym[walk_pos], is_end: 1'b0, last: 1'b0};
          end
          n_found++;
          walk_pos = root_sel;
        end
      end
      // final byte always rearms and goes back to the root
      if (t.final_byte) begin
        decoder_halted = 1'b0;
        walk_pos = root_sel;
      end
      for (b = 0; b < n_found; b++) begin
        found[b].last = (b == n_found - 1);
        pending_symbols.push_back(found[b]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected result: symbol %0d is_end %0d last %0d",
               out_data.symbol, out_data.is_end, out_data.last);
        err_count++;
      end else begin
        front_symbol = pending_symbols.pop_front();
        if (out_data.symbol !== front_symbol.symbol) begin
          $error("symbol: expected %0d, actual %0d", front_symbol.symbol, out_data.symbol);
          err_count++;
        end
        if (out_data.is_end !== front_symbol.is_end) begin
          $error("is_end: expected %0d, actual %0d", front_symbol.is_end, out_data.is_end);
          err_count++;
        end
        if (out_data.last !== front_symbol.last) begin
          $error("last: expected %0d, actual %0d", front_symbol.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: random bursts, mostly short, now and then long;
  // a requested hold-off wins over everything
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (no_idle) begin
      out_stall = 1'b0;
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_stall = 1'b0;
        burst_left = $urandom_range(0, 6);
      end else if (stall_roll < 94) begin
        out_stall = 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        out_stall = 1'b1;
        burst_left = $urandom_range(10, 40);
      end
    end
  end

  // sender gap length in cycles
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input hufd_pkg::hufd_in_t t);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    walk_tree(t);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // load one node; the decode fields carry noise
  task automatic load_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lc,
                           input logic [IDX_W-1:0] rc, input logic leaf,
                           input logic [SYM_W-1:0] sym);
    hufd_pkg::hufd_in_t t;
    t.mode        = hufd_pkg::MODE_LOAD;
    t.node_index  = idx;
    t.left_child  = lc;
    t.right_child = rc;
    t.is_leaf     = leaf;
    t.leaf_symbol = sym;
    t.data_byte   = BYTE_W'($urandom_range(0, 255));
    t.final_byte  = 1'($urandom_range(0, 1));
    send_item(t);
    if (!node_written[idx]) begin
      node_written[idx] = 1'b1;
      written_nodes.push_back(idx);
    end
  endtask

  // one code byte; the load fields carry noise
  task automatic decode_byte(input logic [BYTE_W-1:0] code, input logic fin);
    hufd_pkg::hufd_in_t t;
    t.mode        = hufd_pkg::MODE_DECODE;
    t.node_index  = IDX_W'($urandom_range(0, 511));
    t.left_child  = IDX_W'($urandom_range(0, 511));
    t.right_child = IDX_W'($urandom_range(0, 511));
    t.is_leaf     = 1'($urandom_range(0, 1));
    t.leaf_symbol = SYM_W'($urandom_range(0, 255));
    t.data_byte   = code;
    t.final_byte  = fin;
    send_item(t);
  endtask

  function automatic logic [IDX_W-1:0] any_written_node();
    return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
  endfunction

  // drop valid, drain all results, then let a byte with no result finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  task automatic check_reg(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {sel, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("register %0d: expected %0d, actual %0d", sel, value, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // a root write leaves the walk where it is
    if (sel == hufd_pkg::REG_ROOT) root_sel = value[IDX_W-1:0];
    else end_sym = value[SYM_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_reg(sel, value);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_register_reset();
    check_reg(hufd_pkg::REG_ROOT, 32'd0);
    check_reg(hufd_pkg::REG_END, {24'd0, hufd_pkg::END_RESET});
  endtask

  // fixed tree at root 0:
  //   0 -> (1, 2)   2 -> (3, 511)   511 -> (4, 5)
  //   leaves: 1 = 0x00, 3 = 0xff, 4 = '*', 5 = 0x80
  task automatic test_load_directed_tree();
    load_node(9'd1, 9'd1, 9'd1, 1'b1, 8'h00);
    load_node(9'd3, 9'd3, 9'd3, 1'b1, 8'hFF);
    load_node(9'd4, 9'd4, 9'd4, 1'b1, hufd_pkg::END_RESET);
    load_node(9'd5, 9'd5, 9'd5, 1'b1, 8'h80);
    load_node(9'd511, 9'd4, 9'd5, 1'b0, 8'h00);
    load_node(9'd2, 9'd3, 9'd511, 1'b0, 8'hFF);
    load_node(9'd0, 9'd1, 9'd2, 1'b0, 8'h00);
  endtask

  task automatic test_directed_decode();
    decode_byte(8'h00, 1'b0);   // eight leaves in one byte
    decode_byte(8'hFF, 1'b0);   // two leaves, walk left inside the tree
    decode_byte(8'h7F, 1'b0);   // carried walk hits the end leaf
    load_node(9'd4, 9'd4, 9'd4, 1'b1, hufd_pkg::END_RESET);   // load while halted
    decode_byte(8'h00, 1'b0);   // ignored while halted
    decode_byte(8'h55, 1'b1);   // final byte while halted: rearm only
    decode_byte(8'h01, 1'b1);   // final byte cuts a walk in progress
    decode_byte(8'h80, 1'b0);   // walk restarted from the root
    decode_byte(8'hC0, 1'b1);   // end leaf inside a final byte
    decode_byte(8'h03, 1'b0);   // leaves the walk at node 511
  endtask

  task automatic test_config_changes();
    // new root while the walk sits mid-tree; end moves to the top symbol
    write_reg(hufd_pkg::REG_END, 32'd255);
    write_reg(hufd_pkg::REG_ROOT, 32'd511);
    decode_byte(8'h20, 1'b0);
    decode_byte(8'h00, 1'b1);
    // a leaf as root: its children are still followed; end at symbol zero
    write_reg(hufd_pkg::REG_ROOT, 32'd1);
    write_reg(hufd_pkg::REG_END, 32'd0);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'hFF, 1'b1);
    decode_byte(8'hA5, 1'b0);
    decode_byte(8'h00, 1'b1);
    write_reg(hufd_pkg::REG_ROOT, 32'd0);
    write_reg(hufd_pkg::REG_END, {24'd0, hufd_pkg::END_RESET});
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_left = 300;
    no_idle = 1'b1;
    repeat (24) decode_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    no_idle = 1'b0;
  endtask

  // fresh tree at random indices, built bottom-up so children are always loaded
  task automatic build_random_tree(output logic [IDX_W-1:0] root_out,
                                   output logic [SYM_W-1:0] leaf_pick);
    bit               taken [512];
    logic [IDX_W-1:0] tops [$];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [SYM_W-1:0] sym;
    int               n_leaves;
    int               k;
    int               pick;
    n_leaves = $urandom_range(2, 8);
    for (k = 0; k < 2 * n_leaves - 1; k++) begin
      do idx = IDX_W'($urandom_range(0, 511)); while (taken[idx]);
      taken[idx] = 1'b1;
      if (k < n_leaves) begin
        sym = SYM_W'($urandom_range(0, 255));
        if (k == 0) leaf_pick = sym;
        load_node(idx, idx, idx, 1'b1, sym);
      end else begin
        pick = $urandom_range(0, tops.size() - 1);
        a = tops[pick];
        tops.delete(pick);
        pick = $urandom_range(0, tops.size() - 1);
        b = tops[pick];
        tops.delete(pick);
        load_node(idx, a, b, 1'b0, SYM_W'($urandom_range(0, 255)));
      end
      tops.push_back(idx);
    end
    root_out = tops[0];
  endtask

  task automatic test_random_streams();
    logic [IDX_W-1:0] new_root;
    logic [SYM_W-1:0] leaf_pick;
    int               stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      build_random_tree(new_root, leaf_pick);
      write_reg(hufd_pkg::REG_ROOT, {23'd0, new_root});
      // often make a real leaf the end symbol so streams halt and rearm
      if ($urandom_range(0, 9) < 4) write_reg(hufd_pkg::REG_END, {24'd0, leaf_pick});
      else write_reg(hufd_pkg::REG_END, $urandom_range(0, 255));
      no_idle = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(8, 24)) begin
        // some overwrite noise; children stay within loaded nodes
        if ($urandom_range(0, 99) < 10)
          load_node(IDX_W'($urandom_range(0, 511)), any_written_node(), any_written_node(),
                    1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
        else
          decode_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    err_count      = 0;
    items_sent     = 0;
    cycle_count    = 0;
    hold_left      = 0;
    burst_left     = 0;
    no_idle        = 1'b0;
    walk_pos       = '0;
    decoder_halted = 1'b0;
    root_sel       = '0;
    end_sym        = hufd_pkg::END_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_reset();
    test_load_directed_tree();
    test_directed_decode();
    test_config_changes();
    test_output_backpressure();
    test_random_streams();

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
